>>> rtl/midi_step_sequencer_clock_top_assert.svh
// assertion macros for the step sequencer lane
`ifndef MIDI_STEP_SEQUENCER_CLOCK_TOP_ASSERT_SVH
`define MIDI_STEP_SEQUENCER_CLOCK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that holds at every edge out of reset
`define MSSC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

>>> rtl/mssc_pkg.sv
`default_nettype none
package mssc_pkg;

	// default sizes
	localparam int MAX_STEPS_DEF = 16;
	localparam int PEND_DEPTH_DEF = 4;

	// field widths
	localparam int TIME_W = 32;
	localparam int BEAT_W = 24;
	localparam int CNT_W = 5;
	localparam int NOTE_W = 7;
	localparam int WHOLE_W = BEAT_W + CNT_W;
	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	// register reset values
	localparam logic [BEAT_W-1:0] BEAT_RST = BEAT_W'(24000);
	localparam logic [CNT_W-1:0] STEPS_RST = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_RST = CNT_W'(4);

	// step table entry after reset
	localparam logic [NOTE_W-1:0] NOTE_RST = NOTE_W'(60);
	localparam logic [NOTE_W-1:0] LEVEL_RST = NOTE_W'(127);

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_RESYNC = 2'd1,
		OP_RESET = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_LANE_EN = 2'd0,
		REG_BEAT_PER = 2'd1,
		REG_STEP_CNT = 2'd2,
		REG_BEAT_DIV = 2'd3
	} cfg_reg_t;

	localparam logic EV_NOTE_ON = 1'b0;
	localparam logic EV_NOTE_OFF = 1'b1;

endpackage
`default_nettype wire

>>> rtl/midi_step_sequencer_clock_top.sv
`default_nettype none
// One rhythm lane of a sample-clocked step sequencer. Requests come in on the
// in_valid/in_ready channel; note events leave through a one-entry output
// register on out_valid/out_ready. A tick with no step due passes through the
// mask and emit states and emits each due note-off in turn. A tick on a step
// time first makes two passes of the bit-serial divider, for step period and
// step slot, then reads the step table and queues the note-on of an enabled
// step. A resync makes three divider passes (two when beat period times beat
// divisor is zero), then sets the next step time. Reset and step-table writes
// complete in the idle state. The shared restoring divider, one quotient bit
// a cycle, serves ticks and resyncs; the emit state holds the next event back
// while the output register stays full. Configuration registers sit on an
// APB-style port at byte addresses 0, 4, 8 and 12.
module midi_step_sequencer_clock_top #(
	parameter int MAX_PATTERN_STEPS = mssc_pkg::MAX_STEPS_DEF,
	parameter int PENDING_DEPTH = mssc_pkg::PEND_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration port
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [mssc_pkg::CFG_AW-1:0] paddr,
	input wire logic [mssc_pkg::CFG_DW-1:0] pwdata,
	output logic [mssc_pkg::CFG_DW-1:0] prdata,
	output logic pready,
	// request channel
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] operation,
	input wire logic [3:0] step_index,
	input wire logic step_enable,
	input wire logic [mssc_pkg::NOTE_W-1:0] step_note,
	input wire logic [mssc_pkg::NOTE_W-1:0] step_level,
	// event channel
	output logic out_valid,
	input wire logic out_ready,
	output logic event_kind,
	output logic [mssc_pkg::NOTE_W-1:0] note,
	output logic [mssc_pkg::NOTE_W-1:0] velocity,
	output logic [mssc_pkg::TIME_W-1:0] event_time,
	output logic last,
	output logic overflow
);
	import mssc_pkg::*;

	localparam int SW = $clog2(MAX_PATTERN_STEPS + 1);
	localparam int IW = (MAX_PATTERN_STEPS > 1) ? $clog2(MAX_PATTERN_STEPS) : 1;
	localparam int PW = $clog2(PENDING_DEPTH + 1);
	localparam int PI = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int DIV_W = SW + TIME_W;
	localparam int DCW = $clog2(DIV_W + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_RMOD = 10'b0000000010,
		S_RCEIL = 10'b0000000100,
		S_RPER = 10'b0000001000,
		S_RFIN = 10'b0000010000,
		S_TPER = 10'b0000100000,
		S_TSID = 10'b0001000000,
		S_TON = 10'b0010000000,
		S_MASK = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic lane_en_q;
	logic [BEAT_W-1:0] beat_per_q;
	logic [CNT_W-1:0] step_cnt_q;
	logic [CNT_W-1:0] beat_div_q;

	// sequencer state
	logic [TIME_W-1:0] st_q;
	logic [TIME_W-1:0] next_q;
	logic [SW-1:0] sp_q;
	logic [SW-1:0] sid_q;
	logic [TIME_W-1:0] period_q;
	logic [WHOLE_W-1:0] progress_q;

	// step table with reset-value valid bits
	logic [MAX_PATTERN_STEPS-1:0] tbl_vld_q;
	logic tbl_on_q [MAX_PATTERN_STEPS];
	logic [NOTE_W-1:0] tbl_note_q [MAX_PATTERN_STEPS];
	logic [NOTE_W-1:0] tbl_lvl_q [MAX_PATTERN_STEPS];

	// pending note-off queue, kept compacted
	logic [NOTE_W-1:0] pend_note_q [PENDING_DEPTH];
	logic [TIME_W-1:0] pend_due_q [PENDING_DEPTH];
	logic [PW-1:0] used_q;
	logic [PENDING_DEPTH-1:0] due_mask_q;

	// pending note-on
	logic on_pend_q;
	logic on_ovf_q;
	logic [NOTE_W-1:0] on_note_q;
	logic [NOTE_W-1:0] on_lvl_q;

	// serial divider
	logic [DIV_W-1:0] div_num_q;
	logic [WHOLE_W-1:0] div_rem_q;
	logic [WHOLE_W-1:0] div_den_q;
	logic [DCW-1:0] div_cnt_q;
	logic div_go;
	logic [DIV_W-1:0] div_n;
	logic [WHOLE_W-1:0] div_d;
	logic [WHOLE_W:0] div_tmp;
	logic div_ge;

	// output register
	logic out_vld_q;
	logic kind_q;
	logic [NOTE_W-1:0] note_q;
	logic [NOTE_W-1:0] vel_q;
	logic [TIME_W-1:0] time_q;
	logic last_q;
	logic ovf_q;

	logic [7:0] eff8;
	logic [SW-1:0] eff;
	logic [WHOLE_W-1:0] whole;
	logic cfg_wr;
	logic [IW-1:0] rd_idx;
	logic rd_on;
	logic [NOTE_W-1:0] rd_note;
	logic [NOTE_W-1:0] rd_lvl;
	logic [PI-1:0] k_idx;
	logic [PENDING_DEPTH-1:0] rest_mask;
	logic [PENDING_DEPTH-1:0] shift_mask;
	logic can_load;
	logic out_load;
	logic [SW:0] sid_inc;

	// derived pattern quantities
	always_comb begin
		if (step_cnt_q == '0) begin
			eff8 = 8'd1;
		end else if (8'(step_cnt_q) > 8'(MAX_PATTERN_STEPS)) begin
			eff8 = 8'(MAX_PATTERN_STEPS);
		end else begin
			eff8 = 8'(step_cnt_q);
		end
	end
	assign eff = eff8[SW-1:0];
	assign whole = WHOLE_W'(beat_per_q) * WHOLE_W'(beat_div_q);
	assign sid_inc = (SW+1)'(sid_q) + 1'b1;

	// step table read
	assign rd_idx = sid_q[IW-1:0];
	assign rd_on = tbl_vld_q[rd_idx] ? tbl_on_q[rd_idx] : 1'b1;
	assign rd_note = tbl_vld_q[rd_idx] ? tbl_note_q[rd_idx] : NOTE_RST;
	assign rd_lvl = tbl_vld_q[rd_idx] ? tbl_lvl_q[rd_idx] : LEVEL_RST;

	// lowest due entry and the mask after its removal
	always_comb begin
		k_idx = '0;
		for (int j = PENDING_DEPTH - 1; j >= 0; j--) begin
			if (due_mask_q[j]) begin
				k_idx = PI'(j);
			end
		end
		for (int j = 0; j < PENDING_DEPTH; j++) begin
			if (j < int'(k_idx)) begin
				shift_mask[j] = due_mask_q[j];
			end else if (j < PENDING_DEPTH - 1) begin
				shift_mask[j] = due_mask_q[j+1];
			end else begin
				shift_mask[j] = 1'b0;
			end
		end
		rest_mask = shift_mask;
	end

	assign can_load = !out_vld_q || out_ready;

	// an event enters the output register
	assign out_load = (state_q == S_EMIT) && can_load
		&& (on_pend_q || (lane_en_q && due_mask_q != '0));

	// divider step and operand selection
	assign div_tmp = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge = div_tmp >= {1'b0, div_den_q};

	always_comb begin
		div_go = 1'b0;
		div_n = '0;
		div_d = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && op_t'(operation) == OP_RESYNC) begin
					div_go = 1'b1;
					if (whole != '0) begin
						div_n = DIV_W'(st_q);
						div_d = whole;
					end else begin
						div_n = DIV_W'(whole);
						div_d = WHOLE_W'(eff);
					end
				end else if (in_valid && op_t'(operation) == OP_TICK && lane_en_q
						&& next_q == st_q) begin
					div_go = 1'b1;
					div_n = DIV_W'(whole);
					div_d = WHOLE_W'(eff);
				end
			end
			S_RMOD: begin
				div_go = div_cnt_q == '0;
				div_n = DIV_W'(eff) * DIV_W'(div_rem_q) + DIV_W'(whole) - 1'b1;
				div_d = whole;
			end
			S_RCEIL: begin
				div_go = div_cnt_q == '0;
				div_n = DIV_W'(whole);
				div_d = WHOLE_W'(eff);
			end
			S_TPER: begin
				div_go = div_cnt_q == '0;
				div_n = DIV_W'(sp_q);
				div_d = WHOLE_W'(eff);
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	// bit-serial restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_go) begin
			div_cnt_q <= DCW'(DIV_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_num_q <= div_n;
			div_rem_q <= '0;
			div_den_q <= div_d;
		end else if (div_cnt_q != '0) begin
			div_num_q <= {div_num_q[DIV_W-2:0], div_ge};
			div_rem_q <= div_ge ? WHOLE_W'(div_tmp - {1'b0, div_den_q}) : WHOLE_W'(div_tmp);
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_en_q <= 1'b1;
			beat_per_q <= BEAT_RST;
			step_cnt_q <= STEPS_RST;
			beat_div_q <= DIV_RST;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[3:2]))
				REG_LANE_EN: lane_en_q <= pwdata[0];
				REG_BEAT_PER: beat_per_q <= pwdata[BEAT_W-1:0];
				REG_STEP_CNT: step_cnt_q <= pwdata[CNT_W-1:0];
				REG_BEAT_DIV: beat_div_q <= pwdata[CNT_W-1:0];
				default: lane_en_q <= lane_en_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[3:2]))
			REG_LANE_EN: prdata = CFG_DW'(lane_en_q);
			REG_BEAT_PER: prdata = CFG_DW'(beat_per_q);
			REG_STEP_CNT: prdata = CFG_DW'(step_cnt_q);
			REG_BEAT_DIV: prdata = CFG_DW'(beat_div_q);
			default: prdata = '0;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= '0;
			next_q <= '0;
			sp_q <= '0;
			used_q <= '0;
			due_mask_q <= '0;
			on_pend_q <= 1'b0;
			tbl_vld_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (op_t'(operation))
							OP_RESYNC: begin
								if (whole != '0) begin
									state_q <= S_RMOD;
								end else begin
									progress_q <= '0;
									state_q <= S_RCEIL;
								end
							end
							OP_RESET: begin
								st_q <= '0;
								next_q <= '0;
								sp_q <= '0;
								used_q <= '0;
							end
							OP_WRITE: begin
								if (int'(step_index) < MAX_PATTERN_STEPS) begin
									tbl_vld_q[IW'(step_index)] <= 1'b1;
									tbl_on_q[IW'(step_index)] <= step_enable;
									tbl_note_q[IW'(step_index)] <= step_note;
									tbl_lvl_q[IW'(step_index)] <= step_level;
								end
							end
							default: begin
								if (lane_en_q && next_q == st_q) begin
									state_q <= S_TPER;
								end else begin
									state_q <= S_MASK;
								end
							end
						endcase
					end
				end
				S_RMOD: begin
					if (div_cnt_q == '0) begin
						progress_q <= div_rem_q;
						state_q <= S_RCEIL;
					end
				end
				S_RCEIL: begin
					// when whole and progress are both zero the pointer keeps its value
					if (div_cnt_q == '0) begin
						if (progress_q != '0 || whole != '0) begin
							sp_q <= div_num_q[SW-1:0];
						end
						state_q <= S_RPER;
					end
				end
				S_RPER: begin
					if (div_cnt_q == '0) begin
						period_q <= TIME_W'(div_num_q);
						state_q <= S_RFIN;
					end
				end
				S_RFIN: begin
					next_q <= st_q - TIME_W'(progress_q) + TIME_W'(TIME_W'(sp_q) * period_q);
					state_q <= S_IDLE;
				end
				S_TPER: begin
					if (div_cnt_q == '0) begin
						period_q <= TIME_W'(div_num_q);
						state_q <= S_TSID;
					end
				end
				S_TSID: begin
					if (div_cnt_q == '0) begin
						sid_q <= div_rem_q[SW-1:0];
						state_q <= S_TON;
					end
				end
				S_TON: begin
					// note-on and its queued note-off
					if (rd_on) begin
						on_pend_q <= 1'b1;
						on_note_q <= rd_note;
						on_lvl_q <= rd_lvl;
						on_ovf_q <= !(int'(used_q) < PENDING_DEPTH);
						for (int j = 0; j < PENDING_DEPTH; j++) begin
							if (PW'(j) == used_q) begin
								pend_note_q[j] <= rd_note;
								pend_due_q[j] <= st_q + (period_q >> 2);
							end
						end
						if (int'(used_q) < PENDING_DEPTH) begin
							used_q <= used_q + 1'b1;
						end
					end
					next_q <= st_q + period_q;
					sp_q <= (sid_inc == (SW+1)'(eff)) ? '0 : sid_inc[SW-1:0];
					state_q <= S_MASK;
				end
				S_MASK: begin
					for (int j = 0; j < PENDING_DEPTH; j++) begin
						due_mask_q[j] <= (j < int'(used_q)) && (pend_due_q[j] == st_q);
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (on_pend_q) begin
						if (can_load) begin
							kind_q <= EV_NOTE_ON;
							note_q <= on_note_q;
							vel_q <= on_lvl_q;
							time_q <= st_q;
							last_q <= due_mask_q == '0;
							ovf_q <= on_ovf_q;
							on_pend_q <= 1'b0;
						end
					end else if (due_mask_q != '0) begin
						if (!lane_en_q || can_load) begin
							if (lane_en_q) begin
								kind_q <= EV_NOTE_OFF;
								note_q <= pend_note_q[k_idx];
								vel_q <= '0;
								time_q <= st_q;
								last_q <= rest_mask == '0;
								ovf_q <= 1'b0;
							end
							// remove the entry and close the gap
							for (int j = 0; j < PENDING_DEPTH - 1; j++) begin
								if (j >= int'(k_idx)) begin
									pend_note_q[j] <= pend_note_q[j+1];
									pend_due_q[j] <= pend_due_q[j+1];
								end
							end
							due_mask_q <= shift_mask;
							used_q <= used_q - 1'b1;
						end
					end else begin
						st_q <= st_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = out_vld_q;
	assign event_kind = kind_q;
	assign note = note_q;
	assign velocity = vel_q;
	assign event_time = time_q;
	assign last = last_q;
	assign overflow = ovf_q;

	`include "midi_step_sequencer_clock_top_assert.svh"

	`MSSC_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "state not one-hot")
	`MSSC_ASSERT_ALWAYS(a_used_bound, int'(used_q) <= PENDING_DEPTH, "queue overfilled")
	`MSSC_ASSERT_NOW(a_mask_in_use, state_q == S_EMIT,
		(due_mask_q >> used_q) == '0, "due mask beyond queue fill")
	`MSSC_ASSERT_NOW(a_out_from_emit, $rose(out_vld_q), $past(state_q == S_EMIT),
		"event loaded outside emit")

endmodule
`default_nettype wire
